FILE: design/sfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, constants and arithmetic helpers for the sensor frame
// CRC checker and converter.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Byte positions within a six-byte reply.
    localparam logic [2:0] POS_W0_HI = 3'd0;
    localparam logic [2:0] POS_W0_LO = 3'd1;
    localparam logic [2:0] POS_CRC0  = 3'd2;
    localparam logic [2:0] POS_W1_HI = 3'd3;
    localparam logic [2:0] POS_W1_LO = 3'd4;
    localparam logic [2:0] POS_CRC1  = 3'd5;

    localparam logic [14:0] TEMP_MUL = 15'd17500;
    localparam logic [14:0] HUM_MUL  = 15'd12500;
    localparam logic [15:0] TEMP_OFS = 16'd4500;
    localparam logic [15:0] HUM_OFS  = 16'd600;
    localparam logic [15:0] HUM_MAX  = 16'd10000;

    typedef struct packed {
        logic        first_ok;
        logic        second_ok;
        logic [15:0] word0;
        logic [15:0] word1;
    } t_rec;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Quotient by 65535 for values below 2^31: the first estimate is the
    // upper half, and the remainder stays below twice the divisor.
    function automatic logic [14:0] div_65535(input logic [30:0] x);
        logic [14:0] q0;
        logic [16:0] r;
        q0 = x[30:16];
        r  = {1'b0, x[15:0]} + {2'b00, q0};
        return q0 + ((r >= 17'd65535) ? 15'd1 : 15'd0);
    endfunction

endpackage
`default_nettype wire

FILE: design/sfc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_front
// Accepts reply bytes, tracks the byte position, runs the CRC-8 and
// assembles one frame record on the sixth byte.
// ----------------------------------------------------------------------------
module sfc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_first,
    input  wire logic          i_full,
    output logic               o_push,
    output sfc_pkg::t_rec      o_rec
);
    import sfc_pkg::*;

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_shift, n_shift;
    logic [15:0] r_w0, n_w0;
    logic        r_ok0, n_ok0;

    logic [2:0]  pos;
    logic [7:0]  crc;
    logic [15:0] sh;
    logic        accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        pos = r_pos;
        crc = r_crc;
        sh  = r_shift;
        if (i_first || (r_pos > POS_CRC1)) begin
            pos = POS_W0_HI;
            crc = CRC_INIT;
            sh  = '0;
        end

        n_pos   = r_pos;
        n_crc   = r_crc;
        n_shift = r_shift;
        n_w0    = r_w0;
        n_ok0   = r_ok0;
        o_push  = 1'b0;

        o_rec.first_ok  = r_ok0;
        o_rec.second_ok = (crc == i_byte);
        o_rec.word0     = r_w0;
        o_rec.word1     = sh;

        if (accept) begin
            case (pos)
                POS_W0_HI, POS_W0_LO, POS_W1_HI, POS_W1_LO: begin
                    n_crc   = crc8_byte(crc, i_byte);
                    n_shift = {sh[7:0], i_byte};
                    n_pos   = pos + 3'd1;
                end
                POS_CRC0: begin
                    n_ok0   = (crc == i_byte);
                    n_w0    = sh;
                    n_crc   = CRC_INIT;
                    n_shift = sh;
                    n_pos   = POS_W1_HI;
                end
                POS_CRC1: begin
                    o_push  = 1'b1;
                    n_crc   = CRC_INIT;
                    n_shift = '0;
                    n_pos   = POS_W0_HI;
                end
                default: begin
                    n_crc   = CRC_INIT;
                    n_shift = '0;
                    n_pos   = POS_W0_HI;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_W0_HI;
            r_crc   <= CRC_INIT;
            r_shift <= '0;
            r_w0    <= '0;
            r_ok0   <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_shift <= n_shift;
            r_w0    <= n_w0;
            r_ok0   <= n_ok0;
        end
    end

endmodule
`default_nettype wire

FILE: design/sfc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_queue
// Short first-in first-out queue of frame records between the byte
// front end and the conversion back end.
// ----------------------------------------------------------------------------
module sfc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire sfc_pkg::t_rec  i_rec,
    input  wire logic           i_pop,
    output sfc_pkg::t_rec       o_rec,
    output logic                o_empty,
    output logic                o_full
);
    import sfc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_rec             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/sfc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_back
// Two-stage conversion pipeline: constant multiply, then division by
// 65535, offset and optional humidity clamp into the output register.
// ----------------------------------------------------------------------------
module sfc_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_clamp,
    input  wire logic                        i_avail,
    input  wire sfc_pkg::t_rec               i_rec,
    output logic                             o_pop,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [sfc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import sfc_pkg::*;

    logic        r_v1, r_v2;
    t_rec        r_rec1, r_rec2;
    logic [30:0] r_prod_t;
    logic [29:0] r_prod_h;
    logic [14:0] r_temp, r_hum;

    logic        en1, en2;
    logic [14:0] q_t, q_h;
    logic [15:0] temp16, hum16, hum_c;

    assign en2   = !r_v2 || m_axis_tready;
    assign en1   = !r_v1 || en2;
    assign o_pop = en1 && i_avail;

    always_comb begin
        q_t    = div_65535(r_prod_t);
        q_h    = div_65535({1'b0, r_prod_h});
        temp16 = {1'b0, q_t} - TEMP_OFS;
        hum16  = {1'b0, q_h} - HUM_OFS;
        hum_c  = hum16;
        if (i_clamp) begin
            if ($signed(hum16) < $signed(16'd0)) begin
                hum_c = '0;
            end else if ($signed(hum16) > $signed(HUM_MAX)) begin
                hum_c = HUM_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_rec1   <= i_rec;
            r_prod_t <= 31'(TEMP_MUL) * 31'(i_rec.word0);
            r_prod_h <= 30'(HUM_MUL) * 30'(i_rec.word1);
        end
        if (en2) begin
            r_rec2 <= r_rec1;
            r_temp <= temp16[14:0];
            r_hum  <= hum_c[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_avail;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    assign m_axis_tvalid = r_v2;
    assign m_axis_tdata  = {7'b0, r_hum, r_temp, r_rec2.word1, r_rec2.word0,
                            r_rec2.second_ok, r_rec2.first_ok,
                            r_rec2.first_ok & r_rec2.second_ok};

endmodule
`default_nettype wire

FILE: design/sensor_frame_crc_check_and_convert.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_frame_crc_check_and_convert
// Checks the two CRC-8 bytes of a six-byte sensor reply and converts the
// two raw words to temperature and humidity in hundredths.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat content
// s_axis    in         one reply byte, tuser marks the first byte of a reply
// m_axis    out        one result per complete reply
// cfg       in         humidity clamp enable, written by i_cfg_we
//
// One byte is taken every cycle while the record queue has room.
// After the edge that takes the sixth byte, the record passes through the
// queue and then the conversion stages behind it (multiply, then divide and
// clamp) before m_axis_tvalid rises.
// A stalled output fills the queue, after which s_axis_tready drops.
// Reset is synchronous; it empties the queue and restarts the byte position.
// ----------------------------------------------------------------------------
module sensor_frame_crc_check_and_convert #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] rx_byte
    input  wire logic [sfc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] frame_first
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [0] frame_ok, [1] first_crc_ok, [2] second_crc_ok, [18:3] raw_first_word,
    // [34:19] raw_second_word, [49:35] temp_centi, [64:50] humidity_centi
    output logic [sfc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import sfc_pkg::*;

    logic r_clamp;
    logic push, pop, q_empty, q_full;
    t_rec rec_in, rec_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp <= 1'b1;
        end else if (i_cfg_we) begin
            r_clamp <= i_cfg_wdata;
        end
    end

    sfc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_first (s_axis_tuser),
        .i_full  (q_full),
        .o_push  (push),
        .o_rec   (rec_in)
    );

    sfc_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec_in),
        .i_pop   (pop),
        .o_rec   (rec_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    sfc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clamp       (r_clamp),
        .i_avail       (!q_empty),
        .i_rec         (rec_out),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
`default_nettype wire

FILE: design/sfc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_checker
// Port-level checks on the sensor frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module sfc_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [sfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped during stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output beat changed during stall");

    a_frame_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[1] & m_axis_tdata[2])))
        else $error("frame_ok disagrees with the two CRC flags");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[49:35]) >= -15'sd4500))
        else $error("temperature below the conversion range");

endmodule

bind sensor_frame_crc_check_and_convert sfc_checker u_sfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

FILE: test/sfc_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_frame_checker
// Watches the byte stream, the configuration port and the result stream of
// the sensor frame checker and converter. Every accepted byte is run through
// an independent prediction of the frame position, the CRC-8 and the
// temperature and humidity conversion. Each result beat is compared field by
// field with the oldest predicted reading.
// ----------------------------------------------------------------------------
module sfc_frame_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_wdata,
    input  wire logic                            i_s_tvalid,
    input  wire logic                            i_s_tready,
    // [7:0] rx_byte
    input  wire logic [sfc_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // [0] frame_first
    input  wire logic                            i_s_tuser,
    input  wire logic                            i_m_tvalid,
    input  wire logic                            i_m_tready,
    // [0] frame_ok, [1] first_crc_ok, [2] second_crc_ok, [18:3] raw_first_word,
    // [34:19] raw_second_word, [49:35] temp_centi, [64:50] humidity_centi
    input  wire logic [sfc_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_checked
);
    import sfc_pkg::*;

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic               frame_ok;
        logic               first_ok;
        logic               second_ok;
        logic [15:0]        word0;
        logic [15:0]        word1;
        logic signed [14:0] temp;
        logic signed [14:0] hum;
    } reading_t;

    reading_t    readings_due[$];
    logic        clamp_en   = 1'b1;
    logic [2:0]  pos        = POS_W0_HI;
    logic [7:0]  crc_acc    = CRC_INIT;
    logic [15:0] shift_word = '0;
    logic [15:0] held_word  = '0;
    logic        held_ok    = 1'b0;
    int          fails      = 0;
    int          checked    = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    task automatic report(input string msg);
        if (fails < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        fails++;
    endtask

    function automatic logic [7:0] crc_next(input logic [7:0] c, input logic [7:0] d);
        logic [7:0] r;
        r = c ^ d;
        for (int k = 0; k < 8; k++) begin
            r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    task automatic absorb_byte(input logic [7:0] b, input logic first);
        logic [2:0] p;
        reading_t   r;
        int         t;
        int         h;
        p = pos;
        if (first || p > POS_CRC1) begin
            p          = POS_W0_HI;
            crc_acc    = CRC_INIT;
            shift_word = '0;
        end
        case (p)
            POS_CRC0: begin
                held_ok   = (crc_acc == b);
                held_word = shift_word;
                crc_acc   = CRC_INIT;
                pos       = POS_W1_HI;
            end
            POS_CRC1: begin
                t = int'((32'd17500 * {16'd0, held_word}) / 32'd65535) - 4500;
                h = int'((32'd12500 * {16'd0, shift_word}) / 32'd65535) - 600;
                if (clamp_en) begin
                    if (h > 10000) h = 10000;
                    if (h < 0) h = 0;
                end
                r.second_ok = (crc_acc == b);
                r.first_ok  = held_ok;
                r.frame_ok  = held_ok && r.second_ok;
                r.word0     = held_word;
                r.word1     = shift_word;
                r.temp      = t[14:0];
                r.hum       = h[14:0];
                readings_due.push_back(r);
                crc_acc    = CRC_INIT;
                shift_word = '0;
                pos        = POS_W0_HI;
            end
            default: begin
                crc_acc    = crc_next(crc_acc, b);
                shift_word = {shift_word[7:0], b};
                pos        = p + 3'd1;
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [15:0] expv,
                                 input logic [15:0] gotv);
        if (expv !== gotv) begin
            report($sformatf("%s expected %h got %h", name, expv, gotv));
        end
    endtask

    task automatic check_reading(input reading_t e, input logic [OUT_TDATA_W-1:0] d);
        compare_field("frame_ok", 16'(e.frame_ok), 16'(d[0]));
        compare_field("first_crc_ok", 16'(e.first_ok), 16'(d[1]));
        compare_field("second_crc_ok", 16'(e.second_ok), 16'(d[2]));
        compare_field("raw_first_word", e.word0, d[18:3]);
        compare_field("raw_second_word", e.word1, d[34:19]);
        compare_field("temp_centi", {1'b0, e.temp}, {1'b0, d[49:35]});
        compare_field("humidity_centi", {1'b0, e.hum}, {1'b0, d[64:50]});
        compare_field("padding", 16'd0, 16'(d[OUT_TDATA_W-1:65]));
    endtask

    always @(posedge i_clk) begin
        reading_t e;
        if (!i_rst_n) begin
            clamp_en   = 1'b1;
            pos        = POS_W0_HI;
            crc_acc    = CRC_INIT;
            shift_word = '0;
            held_word  = '0;
            held_ok    = 1'b0;
            readings_due.delete();
        end else begin
            if (i_cfg_we) begin
                clamp_en = i_cfg_wdata;
            end
            if (i_m_tvalid && i_m_tready) begin
                if (readings_due.size() == 0) begin
                    report($sformatf("result beat %h with no reply pending", i_m_tdata));
                end else begin
                    e = readings_due.pop_front();
                    check_reading(e, i_m_tdata);
                    checked++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                absorb_byte(i_s_tdata, i_s_tuser);
            end
        end
        o_pending    <= readings_due.size();
        o_checked    <= checked;
        o_fail_count <= fails;
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sensor frame checker and converter. Sends
// directed replies at the word extremes, with CRC faults, restarts and a
// reply without a first-byte mark, then random replies, truncated replies
// and noise under both clamp settings, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb;
    import sfc_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int SETTLE       = 12;
    localparam int LIMIT        = 400000;
    localparam int RANDOM_BYTES = 170;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic                   cfg_wdata   = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;
    logic                   s_tuser     = 1'b0;
    logic                   m_tready    = 1'b0;
    wire logic              s_tready;
    wire logic              m_tvalid;
    wire logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int checked;
    int bytes_sent  = 0;
    int frames_sent = 0;
    int cycle_count = 0;
    bit no_idle     = 1'b0;

    always #4 i_clk = ~i_clk;

    sensor_frame_crc_check_and_convert dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    sfc_frame_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int n;
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 10);
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        logic [7:0] c;
        c = CRC_INIT;
        for (int k = 15; k >= 0; k--) begin
            c = (c[7] ^ w[k]) ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 3200));
            3: return 16'($urandom_range(57000, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [15:0] w0, input logic [15:0] w1,
                              input bit bad0, input bit bad1, input bit marked);
        logic [7:0] c0;
        logic [7:0] c1;
        c0 = word_crc(w0) ^ (bad0 ? 8'($urandom_range(1, 255)) : 8'h00);
        c1 = word_crc(w1) ^ (bad1 ? 8'($urandom_range(1, 255)) : 8'h00);
        send_byte(w0[15:8], marked);
        send_byte(w0[7:0], 1'b0);
        send_byte(c0, 1'b0);
        send_byte(w1[15:8], 1'b0);
        send_byte(w1[7:0], 1'b0);
        send_byte(c1, 1'b0);
        frames_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_clamp(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int target;
        int n;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_clamp(1'b1);
        send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1);
        // Next reply follows without a first-byte mark.
        send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b0);
        // A truncated reply is dropped by the marked restart.
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_frame(16'h8000, 16'h5555, 1'b0, 1'b1, 1'b1);
        wait_idle();
        write_clamp(1'b0);
        send_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
        send_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        wait_idle();

        for (int phase = 0; phase < 4; phase++) begin
            write_clamp(phase[0]);
            target = bytes_sent + RANDOM_BYTES;
            while (bytes_sent < target) begin
                if ($urandom_range(0, 19) == 0) begin
                    no_idle = ~no_idle;
                end
                case ($urandom_range(0, 19))
                    0, 1: begin
                        send_frame(pick_word(), pick_word(), $urandom_range(0, 1),
                                   $urandom_range(0, 1), 1'b1);
                    end
                    2, 3: begin
                        n = $urandom_range(1, 5);
                        for (int k = 0; k < n; k++) begin
                            send_byte(8'($urandom), k == 0);
                        end
                    end
                    4: begin
                        n = $urandom_range(1, 8);
                        for (int k = 0; k < n; k++) begin
                            send_byte(8'($urandom), $urandom_range(0, 3) == 0);
                        end
                    end
                    default: begin
                        send_frame(pick_word(), pick_word(), 1'b0, 1'b0,
                                   $urandom_range(0, 6) != 0);
                    end
                endcase
            end
            no_idle = 1'b0;
            wait_idle();
        end

        $display("Drove %0d reply bytes, %0d of them in whole replies, and checked %0d results.",
                 bytes_sent, frames_sent * 6, checked);
        $display("Covered both clamp settings, CRC faults, restarts, truncation and noise.");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/sfc_pkg.sv
design/sfc_front.sv
design/sfc_queue.sv
design/sfc_back.sv
design/sensor_frame_crc_check_and_convert.sv
design/sfc_checker.sv
test/sfc_frame_checker.sv
test/tb.sv
